[rtl/chd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked deframer package
// Shared constants, codes and beat types of the chunked body deframer.
// ----------------------------------------------------------------------------
package chd_pkg;

  // Longest chunk size field, in hex digits, leading zeros included.
  localparam int SIZE_DIGITS_MAX = 8;
  // Width of the running content counter.
  localparam int LENGTH_WIDTH = 32;
  localparam int DIGIT_CNT_W = $clog2(SIZE_DIGITS_MAX + 1);

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_SP = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;

  typedef enum logic [3:0] {
    PH_SIZE       = 4'd0,
    PH_SIZE_WS    = 4'd1,
    PH_EXT        = 4'd2,
    PH_SIZE_LF    = 4'd3,
    PH_DATA       = 4'd4,
    PH_DATA_CR    = 4'd5,
    PH_DATA_LF    = 4'd6,
    PH_TRAILER    = 4'd7,
    PH_TRAILER_LF = 4'd8,
    PH_DONE       = 4'd9,
    PH_ERROR      = 4'd10
  } phase_t;

  typedef enum logic [2:0] {
    KIND_FRAMING = 3'd0,
    KIND_CONTENT = 3'd1,
    KIND_TRAILER = 3'd2,
    KIND_DONE    = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_SIZE  = 3'd1,
    ERR_OVERSIZE  = 3'd2,
    ERR_DATA_CRLF = 3'd3,
    ERR_LINE_END  = 3'd4
  } err_t;

  typedef enum logic {
    REG_PASS_TRAILERS  = 1'b0,
    REG_MAX_CHUNK_SIZE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    kind_t       kind;
    err_t        error_code;
    logic [31:0] content_length;
  } result_t;

endpackage

[rtl/chd_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked deframer configuration channel
// Register write beats: index and data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface chd_cfg_if
  import chd_pkg::*;
;
  logic        valid;
  logic        ready;
  reg_idx_t    index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/chd_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked deframer input channel
// One raw body byte per beat, with a flag that opens a new message.
// ----------------------------------------------------------------------------
interface chd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       message_start;

  modport source (output valid, output in_byte, output message_start, input ready);
  modport sink (input valid, input in_byte, input message_start, output ready);
endinterface

[rtl/chd_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked deframer result channel
// One classified byte per beat, with error code and content count.
// ----------------------------------------------------------------------------
interface chd_out_if
  import chd_pkg::*;
;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  kind_t       kind;
  err_t        error_code;
  logic [31:0] content_length;

  modport source (output valid, output out_byte, output kind, output error_code,
                  output content_length, input ready);
  modport sink (input valid, input out_byte, input kind, input error_code,
                input content_length, output ready);
endinterface

[rtl/http_chunked_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP/1.1 chunked body deframer
// Classifies every byte of a chunked body as framing, content, trailer,
// message complete or error, and counts the decoded content bytes.
// ----------------------------------------------------------------------------
// The deframer takes one body byte per beat and returns exactly one result
// beat for it, registered in the output register or, while that is still
// occupied, in the skid slot. The parser state is updated at the clock edge
// that accepts a byte; the parse step between the input handshake and the
// result register is combinational, so the throughput is one byte per cycle
// while input ready is high. A second result slot behind the output register
// lets a byte be accepted while an earlier result is still waiting; input
// ready falls only when both slots are full. Setting message_start on a beat
// restarts the parser before that byte is parsed (configuration is kept).
// Once an error is detected it is latched, and every later byte reports kind
// error with the same code until the next message_start. After the empty line
// that ends the trailers, later bytes are reported as framing. Configuration
// must be written while the block is idle.
// ----------------------------------------------------------------------------
module http_chunked_deframer
  import chd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  chd_cfg_if.sink   cfg,
  chd_in_if.sink    in_ch,
  chd_out_if.source out_ch
);

  // Configuration registers.
  logic        pass_trailers;
  logic [31:0] max_chunk_size;

  // Parser state.
  phase_t                   phase;
  logic [31:0]              size_acc;
  logic [DIGIT_CNT_W-1:0]   digit_count;
  logic [31:0]              data_remaining;
  logic                     trailer_line_empty;
  logic [LENGTH_WIDTH-1:0]  total_length;
  err_t                     latched_error;

  // State as seen by the current byte, after an optional restart.
  phase_t                   ph_cur;
  logic [31:0]              acc_cur;
  logic [DIGIT_CNT_W-1:0]   cnt_cur;
  logic [31:0]              rem_cur;
  logic                     tle_cur;
  logic [LENGTH_WIDTH-1:0]  total_cur;
  err_t                     err_cur;

  phase_t                   phase_next;
  logic [31:0]              size_acc_next;
  logic [DIGIT_CNT_W-1:0]   digit_count_next;
  logic [31:0]              data_remaining_next;
  logic                     trailer_line_empty_next;
  logic [LENGTH_WIDTH-1:0]  total_length_next;
  err_t                     latched_error_next;
  kind_t                    kind_now;

  // Result slots: the output register and a skid slot behind it.
  result_t out_data;
  logic    out_valid;
  result_t skid_data;
  logic    skid_valid;
  result_t res_now;

  logic accept;
  logic pop;

  // Byte decode.
  logic       c_is_hex;
  logic [3:0] c_hex;
  logic       c_is_ws;
  logic [7:0] c;
  logic [31:0] acc_shift;
  logic       digit_oversize;
  logic [31:0] rem_dec;

  assign c = in_ch.in_byte;
  assign accept = in_ch.valid && in_ch.ready;
  assign pop = out_valid && out_ch.ready;
  assign in_ch.ready = !skid_valid;
  assign cfg.ready = 1'b1;

  always_comb begin
    c_is_hex = 1'b1;
    c_hex = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      c_hex = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      c_hex = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      c_hex = 4'(c - 8'h37);
    end else begin
      c_is_hex = 1'b0;
    end
  end

  assign c_is_ws = (c == CHAR_SP) || (c == CHAR_TAB);

  // Message start clears everything but the configuration before parsing.
  always_comb begin
    if (in_ch.message_start) begin
      ph_cur    = PH_SIZE;
      acc_cur   = '0;
      cnt_cur   = '0;
      rem_cur   = '0;
      tle_cur   = 1'b1;
      total_cur = '0;
      err_cur   = ERR_NONE;
    end else begin
      ph_cur    = phase;
      acc_cur   = size_acc;
      cnt_cur   = digit_count;
      rem_cur   = data_remaining;
      tle_cur   = trailer_line_empty;
      total_cur = total_length;
      err_cur   = latched_error;
    end
  end

  assign acc_shift = {acc_cur[27:0], c_hex};
  // A digit is too many when the field is already full or the value would
  // carry out of 32 bits.
  assign digit_oversize = (cnt_cur >= DIGIT_CNT_W'(SIZE_DIGITS_MAX)) ||
                          (acc_cur[31:28] != 4'd0);
  assign rem_dec = (rem_cur != 32'd0) ? rem_cur - 32'd1 : 32'd0;

  // Next-state block: phase and the datapath registers.
  always_comb begin
    phase_next              = ph_cur;
    size_acc_next           = acc_cur;
    digit_count_next        = cnt_cur;
    data_remaining_next     = rem_cur;
    trailer_line_empty_next = tle_cur;
    total_length_next       = total_cur;
    latched_error_next      = err_cur;
    unique case (ph_cur)
      PH_SIZE: begin
        if (c_is_hex) begin
          if (digit_oversize || (acc_shift > max_chunk_size)) begin
            phase_next = PH_ERROR;
            latched_error_next = ERR_OVERSIZE;
          end else begin
            size_acc_next = acc_shift;
            digit_count_next = cnt_cur + DIGIT_CNT_W'(1);
          end
        end else if (cnt_cur == '0) begin
          phase_next = PH_ERROR;
          latched_error_next = ERR_BAD_SIZE;
        end else if (c_is_ws) begin
          phase_next = PH_SIZE_WS;
        end else if (c == CHAR_SEMI) begin
          phase_next = PH_EXT;
        end else if (c == CHAR_CR) begin
          phase_next = PH_SIZE_LF;
        end else begin
          phase_next = PH_ERROR;
          latched_error_next = (c == CHAR_LF) ? ERR_LINE_END : ERR_BAD_SIZE;
        end
      end
      PH_SIZE_WS: begin
        if (c_is_ws) begin
          phase_next = PH_SIZE_WS;
        end else if (c == CHAR_SEMI) begin
          phase_next = PH_EXT;
        end else if (c == CHAR_CR) begin
          phase_next = PH_SIZE_LF;
        end else begin
          phase_next = PH_ERROR;
          latched_error_next = (c == CHAR_LF) ? ERR_LINE_END : ERR_BAD_SIZE;
        end
      end
      PH_EXT: begin
        if (c == CHAR_CR) begin
          phase_next = PH_SIZE_LF;
        end else if (c == CHAR_LF) begin
          phase_next = PH_ERROR;
          latched_error_next = ERR_LINE_END;
        end
      end
      PH_SIZE_LF: begin
        if (c != CHAR_LF) begin
          phase_next = PH_ERROR;
          latched_error_next = ERR_LINE_END;
        end else if (acc_cur == 32'd0) begin
          trailer_line_empty_next = 1'b1;
          phase_next = PH_TRAILER;
        end else begin
          data_remaining_next = acc_cur;
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        if (total_cur != '1) begin
          total_length_next = total_cur + LENGTH_WIDTH'(1);
        end
        data_remaining_next = rem_dec;
        if (rem_dec == 32'd0) begin
          phase_next = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        if (c == CHAR_CR) begin
          phase_next = PH_DATA_LF;
        end else begin
          phase_next = PH_ERROR;
          latched_error_next = ERR_DATA_CRLF;
        end
      end
      PH_DATA_LF: begin
        if (c == CHAR_LF) begin
          size_acc_next = '0;
          digit_count_next = '0;
          phase_next = PH_SIZE;
        end else begin
          phase_next = PH_ERROR;
          latched_error_next = ERR_DATA_CRLF;
        end
      end
      PH_TRAILER: begin
        if (c == CHAR_CR) begin
          phase_next = PH_TRAILER_LF;
        end else if (c == CHAR_LF) begin
          phase_next = PH_ERROR;
          latched_error_next = ERR_LINE_END;
        end else begin
          trailer_line_empty_next = 1'b0;
        end
      end
      PH_TRAILER_LF: begin
        if (c != CHAR_LF) begin
          phase_next = PH_ERROR;
          latched_error_next = ERR_LINE_END;
        end else if (tle_cur) begin
          phase_next = PH_DONE;
        end else begin
          trailer_line_empty_next = 1'b1;
          phase_next = PH_TRAILER;
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_ERROR;
      end
    endcase
  end

  // Output block: the kind of result this byte produces.
  always_comb begin
    kind_now = KIND_FRAMING;
    if (phase_next == PH_ERROR) begin
      kind_now = KIND_ERROR;
    end else begin
      unique case (ph_cur)
        PH_DATA: begin
          kind_now = KIND_CONTENT;
        end
        PH_TRAILER: begin
          // The CR of the empty closing line stays framing.
          if (pass_trailers && (c != CHAR_CR || !tle_cur)) begin
            kind_now = KIND_TRAILER;
          end
        end
        PH_TRAILER_LF: begin
          if (tle_cur) begin
            kind_now = KIND_DONE;
          end else if (pass_trailers) begin
            kind_now = KIND_TRAILER;
          end
        end
        default: begin
          kind_now = KIND_FRAMING;
        end
      endcase
    end
  end

  always_comb begin
    res_now.out_byte = c;
    res_now.kind = kind_now;
    res_now.error_code = (kind_now == KIND_ERROR) ? latched_error_next : ERR_NONE;
    res_now.content_length = 32'(total_length_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_trailers  <= 1'b0;
      max_chunk_size <= 32'hFFFF_FFFF;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_PASS_TRAILERS:  pass_trailers <= cfg.data[0];
        REG_MAX_CHUNK_SIZE: max_chunk_size <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_SIZE;
      size_acc           <= '0;
      digit_count        <= '0;
      data_remaining     <= '0;
      trailer_line_empty <= 1'b1;
      total_length       <= '0;
      latched_error      <= ERR_NONE;
    end else if (accept) begin
      phase              <= phase_next;
      size_acc           <= size_acc_next;
      digit_count        <= digit_count_next;
      data_remaining     <= data_remaining_next;
      trailer_line_empty <= trailer_line_empty_next;
      total_length       <= total_length_next;
      latched_error      <= latched_error_next;
    end
  end

  // Result slots. The skid slot always drains into the output register first,
  // so results leave in order.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (accept) begin
      if (!out_valid || pop) begin
        out_data <= res_now;
      end else begin
        skid_data <= res_now;
      end
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.out_byte       = out_data.out_byte;
  assign out_ch.kind           = out_data.kind;
  assign out_ch.error_code     = out_data.error_code;
  assign out_ch.content_length = out_data.content_length;

  // The skid slot is only used while the output register is occupied.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot holds a result while the output register is empty");

  // A parse error always carries a nonzero code in the latch.
  a_error_latched: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ERROR) |-> (latched_error != ERR_NONE))
    else $error("error phase without a latched error code");

  // Error results always carry a code, other results never do.
  a_error_code_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.kind == KIND_ERROR) == (out_data.error_code != ERR_NONE)))
    else $error("error code does not agree with the result kind");

  // The content count never falls within one message.
  a_length_monotonic: assert property (@(posedge clk) disable iff (rst)
    (accept && !in_ch.message_start) |=> (total_length >= $past(total_length)))
    else $error("content count decreased without a message start");

  // An accepted byte with a free result slot is visible on the next cycle.
  a_result_appears: assert property (@(posedge clk) disable iff (rst)
    (accept && !out_valid) |=> out_valid)
    else $error("accepted byte produced no result");

endmodule

[verif/tb_http_chunked_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked deframer testbench
// Drives chunked bodies byte by byte into the deframer, predicts the class of
// every byte with a cycle-free model of the parser, and compares each result
// beat field by field under several register settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_http_chunked_deframer;
  import chd_pkg::*;

  // Upper bound on the run length; a run that passes it is ended as failed.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Random bytes per idling phase; four phases make up the random part.
  localparam int unsigned BYTES_PER_PHASE = 475;
  // Cycles left for the result path to settle once nothing is expected.
  localparam int unsigned SETTLE_CYCLES = 8;

  // --------------------------------------------------------------------------
  // Byte classifier and result checker.
  // predict_byte() steps a private copy of the parser for every accepted input
  // beat and queues the result it must produce; check_result() compares each
  // result beat with the oldest queued prediction.
  // --------------------------------------------------------------------------
  class byte_class_checker;
    logic        pass_trailers;
    logic [31:0] max_chunk_size;

    phase_t      ph;
    logic [31:0] size_acc;
    int unsigned digits;
    logic [31:0] data_left;
    bit          line_empty;
    logic [31:0] content_total;
    err_t        held_err;

    result_t     expected_results[$];
    int unsigned mismatches;

    function new();
      pass_trailers  = 1'b0;
      max_chunk_size = '1;
      mismatches     = 0;
      restart();
    endfunction

    function void restart();
      ph            = PH_SIZE;
      size_acc      = '0;
      digits        = 0;
      data_left     = '0;
      line_empty    = 1'b1;
      content_total = '0;
      held_err      = ERR_NONE;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_PASS_TRAILERS:  pass_trailers = value[0];
        REG_MAX_CHUNK_SIZE: max_chunk_size = value;
        default: ;
      endcase
    endfunction

    function kind_t fail_with(err_t code);
      held_err = code;
      ph       = PH_ERROR;
      return KIND_ERROR;
    endfunction

    function void predict_byte(logic [7:0] c, logic start);
      kind_t       k;
      int          hv;
      logic [31:0] nv;
      result_t     r;
      k = KIND_FRAMING;
      if (start) restart();
      hv = -1;
      if (c >= "0" && c <= "9") hv = c - "0";
      else if (c >= "a" && c <= "f") hv = c - "a" + 10;
      else if (c >= "A" && c <= "F") hv = c - "A" + 10;
      case (ph)
        PH_SIZE: begin
          if (hv >= 0) begin
            if (digits >= SIZE_DIGITS_MAX || size_acc > 32'h0FFF_FFFF) begin
              k = fail_with(ERR_OVERSIZE);
            end else begin
              nv = {size_acc[27:0], hv[3:0]};
              if (nv > max_chunk_size) begin
                k = fail_with(ERR_OVERSIZE);
              end else begin
                size_acc = nv;
                digits++;
              end
            end
          end else if (digits == 0) begin
            k = fail_with(ERR_BAD_SIZE);
          end else if (c == CHAR_SP || c == CHAR_TAB) begin
            ph = PH_SIZE_WS;
          end else if (c == CHAR_SEMI) begin
            ph = PH_EXT;
          end else if (c == CHAR_CR) begin
            ph = PH_SIZE_LF;
          end else if (c == CHAR_LF) begin
            k = fail_with(ERR_LINE_END);
          end else begin
            k = fail_with(ERR_BAD_SIZE);
          end
        end
        PH_SIZE_WS: begin
          if (c == CHAR_SP || c == CHAR_TAB) begin
          end else if (c == CHAR_SEMI) begin
            ph = PH_EXT;
          end else if (c == CHAR_CR) begin
            ph = PH_SIZE_LF;
          end else if (c == CHAR_LF) begin
            k = fail_with(ERR_LINE_END);
          end else begin
            k = fail_with(ERR_BAD_SIZE);
          end
        end
        PH_EXT: begin
          if (c == CHAR_CR) ph = PH_SIZE_LF;
          else if (c == CHAR_LF) k = fail_with(ERR_LINE_END);
        end
        PH_SIZE_LF: begin
          if (c != CHAR_LF) begin
            k = fail_with(ERR_LINE_END);
          end else if (size_acc == 0) begin
            line_empty = 1'b1;
            ph         = PH_TRAILER;
          end else begin
            data_left = size_acc;
            ph        = PH_DATA;
          end
        end
        PH_DATA: begin
          k = KIND_CONTENT;
          if (content_total != '1) content_total++;
          if (data_left > 0) data_left--;
          if (data_left == 0) ph = PH_DATA_CR;
        end
        PH_DATA_CR: begin
          if (c == CHAR_CR) ph = PH_DATA_LF;
          else k = fail_with(ERR_DATA_CRLF);
        end
        PH_DATA_LF: begin
          if (c == CHAR_LF) begin
            size_acc = '0;
            digits   = 0;
            ph       = PH_SIZE;
          end else begin
            k = fail_with(ERR_DATA_CRLF);
          end
        end
        PH_TRAILER: begin
          if (c == CHAR_CR) begin
            ph = PH_TRAILER_LF;
            if (!line_empty && pass_trailers) k = KIND_TRAILER;
          end else if (c == CHAR_LF) begin
            k = fail_with(ERR_LINE_END);
          end else begin
            line_empty = 1'b0;
            if (pass_trailers) k = KIND_TRAILER;
          end
        end
        PH_TRAILER_LF: begin
          if (c != CHAR_LF) begin
            k = fail_with(ERR_LINE_END);
          end else if (line_empty) begin
            k  = KIND_DONE;
            ph = PH_DONE;
          end else begin
            if (pass_trailers) k = KIND_TRAILER;
            line_empty = 1'b1;
            ph         = PH_TRAILER;
          end
        end
        PH_DONE: ;
        default: begin
          ph = PH_ERROR;
          k  = KIND_ERROR;
        end
      endcase
      r.out_byte       = c;
      r.kind           = k;
      r.error_code     = ERR_NONE;
      if (k == KIND_ERROR) r.error_code = held_err;
      r.content_length = content_total;
      expected_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("result beat with no prediction: byte %h kind %0d", got.out_byte, got.kind);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
        mismatches++;
      end
      if (got.error_code !== want.error_code) begin
        $error("error_code: expected %0d, actual %0d", want.error_code, got.error_code);
        mismatches++;
      end
      if (got.content_length !== want.content_length) begin
        $error("content_length: expected %0d, actual %0d",
               want.content_length, got.content_length);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the channels around the block.
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  chd_cfg_if cfg_bus ();
  chd_in_if  in_bus ();
  chd_out_if out_bus ();

  http_chunked_deframer u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  byte_class_checker checker_h = new();

  // Chance, in percent, that the sender idles or the receiver stalls in a cycle.
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned cycles    = 0;

  // Bytes of the body currently being built, first byte opens the message.
  logic [7:0] body_q[$];

  // Everything the block reads is known from time zero on.
  initial begin
    rst                   = 1'b1;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = REG_PASS_TRAILERS;
    cfg_bus.data          = '0;
    in_bus.valid          = 1'b0;
    in_bus.in_byte        = '0;
    in_bus.message_start  = 1'b0;
    out_bus.ready         = 1'b0;
  end

  // The receiver decides at every falling edge whether it takes a beat in the
  // next cycle, so stalls land on every phase of the parser.
  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  // All handshakes are observed in one place at the rising edge. The result
  // beat is checked before the input beat of the same edge is predicted; the
  // block registers its result, so the order only matters for safety.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_bus.valid && cfg_bus.ready) checker_h.set_reg(cfg_bus.index, cfg_bus.data);
      if (out_bus.valid && out_bus.ready) begin
        checker_h.check_result('{out_byte:       out_bus.out_byte,
                                 kind:           out_bus.kind,
                                 error_code:     out_bus.error_code,
                                 content_length: out_bus.content_length});
      end
      if (in_bus.valid && in_bus.ready) checker_h.predict_byte(in_bus.in_byte,
                                                               in_bus.message_start);
    end
  end

  // A run that hangs is ended here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_http_chunked_deframer failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers. Every task is entered and left at a falling edge.
  // --------------------------------------------------------------------------

  // Writes one register; the valid is dropped at the falling edge after the write
  // beat so that a following write raises it in a later time step.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Offers one body byte after a random number of idle cycles and waits for
  // the beat. Valid stays high when the next byte follows without a gap.
  task automatic send_beat(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.in_byte       <= b;
    in_bus.message_start <= start;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  task automatic send_body(inout int unsigned sent);
    foreach (body_q[i]) send_beat(body_q[i], i == 0);
    sent += body_q.size();
  endtask

  // Waits until every predicted result has come back, then lets the result
  // path settle. The input valid must already be low.
  task automatic drain(input int unsigned settle);
    while (checker_h.pending() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Body builders.
  // --------------------------------------------------------------------------
  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endtask

  task automatic push_crlf();
    body_q.push_back(CHAR_CR);
    body_q.push_back(CHAR_LF);
  endtask

  // Any byte that cannot end a line, for extensions and trailer text.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CHAR_CR || b == CHAR_LF);
    return b;
  endfunction

  // A size line in mixed-case hex, sometimes zero padded (now and then past
  // the digit limit), with optional blanks and an optional extension.
  task automatic push_size_line(input logic [31:0] size);
    int unsigned nd;
    int unsigned pad;
    logic [3:0]  nib;
    nd = 1;
    while (nd < 8 && (size >> (4 * nd)) != 0) nd++;
    pad = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0;
    if ($urandom_range(0, 19) == 0) pad = 9 - nd;
    repeat (pad) body_q.push_back("0");
    for (int i = nd - 1; i >= 0; i--) begin
      nib = 4'(size >> (4 * i));
      if (nib < 10) body_q.push_back(8'("0" + nib));
      else if ($urandom_range(1)) body_q.push_back(8'("A" + nib - 10));
      else body_q.push_back(8'("a" + nib - 10));
    end
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 2)) body_q.push_back($urandom_range(1) ? CHAR_SP : CHAR_TAB);
    end
    if ($urandom_range(0, 4) == 0) begin
      body_q.push_back(CHAR_SEMI);
      repeat ($urandom_range(0, 4)) body_q.push_back(text_byte());
    end
    push_crlf();
  endtask

  // Most bodies are well formed with random content, so the parser reaches
  // the data, trailer and completion states; some are damaged by one changed or
  // inserted byte or a cut tail, and a few are plain noise.
  task automatic build_body();
    int unsigned sz;
    int unsigned pos;
    body_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) body_q.push_back(8'($urandom));
      return;
    end
    repeat ($urandom_range(0, 3)) begin
      sz = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      push_size_line(sz);
      repeat (sz) body_q.push_back(8'($urandom));
      push_crlf();
    end
    push_size_line(0);
    repeat ($urandom_range(0, 2)) begin
      repeat ($urandom_range(1, 6)) body_q.push_back(text_byte());
      push_crlf();
    end
    push_crlf();
    // Bytes after completion are only reported as framing.
    repeat ($urandom_range(0, 2)) body_q.push_back(8'($urandom));
    if ($urandom_range(0, 4) == 0) begin
      pos = $urandom_range(0, body_q.size() - 1);
      case ($urandom_range(0, 2))
        0: body_q[pos] = 8'($urandom);
        1: body_q.insert(pos, 8'($urandom));
        default: while (body_q.size() > pos + 1) void'(body_q.pop_back());
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned sent;
    logic        pass_sel;
    logic [31:0] max_sel;
    sent = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed bodies under the reset settings. A complete message with an
    // extension, a zero content byte, a trailer line that is consumed as
    // framing, and a byte after completion.
    body_q.delete();
    push_text("1;");
    push_crlf();
    body_q.push_back(8'h00);
    push_crlf();
    push_text("0");
    push_crlf();
    push_text("T");
    push_crlf();
    push_crlf();
    body_q.push_back(8'hFF);
    send_body(sent);
    // A bare LF where the size should start.
    body_q.delete();
    body_q.push_back(CHAR_LF);
    send_body(sent);
    // An empty size, then a byte that must repeat the latched error.
    body_q.delete();
    body_q.push_back(CHAR_SEMI);
    body_q.push_back(8'hFF);
    send_body(sent);
    // A CR that is not followed by LF on the size line.
    body_q.delete();
    push_text("1");
    body_q.push_back(CHAR_CR);
    push_text("A");
    send_body(sent);
    // Data not followed by CRLF.
    body_q.delete();
    push_text("1");
    push_crlf();
    push_text("AB");
    send_body(sent);
    in_bus.valid <= 1'b0;

    // Random phases, each with its own register setting and idling pattern.
    for (int p = 0; p < 4; p++) begin
      drain(SETTLE_CYCLES);
      case (p)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          pass_sel  = 1'b0;
          max_sel   = '1;
        end
        1: begin
          idle_pct  = 76;
          stall_pct = 0;
          pass_sel  = 1'b1;
          max_sel   = 32'h10;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 76;
          pass_sel  = 1'b0;
          max_sel   = '0;
        end
        default: begin
          idle_pct  = 6;
          stall_pct = 6;
          pass_sel  = 1'b1;
          max_sel   = $urandom_range(8, 40);
        end
      endcase
      write_reg(REG_PASS_TRAILERS, {31'b0, pass_sel});
      write_reg(REG_MAX_CHUNK_SIZE, max_sel);
      sent = 0;
      while (sent < BYTES_PER_PHASE) begin
        build_body();
        send_body(sent);
      end
      in_bus.valid <= 1'b0;
    end

    drain(SETTLE_CYCLES);
    if (checker_h.mismatches == 0) begin
      $display("tb_http_chunked_deframer passed");
    end else begin
      $display("tb_http_chunked_deframer failed");
    end
    $finish;
  end

endmodule

[http_chunked_deframer.f]
rtl/chd_pkg.sv
rtl/chd_cfg_if.sv
rtl/chd_in_if.sv
rtl/chd_out_if.sv
rtl/http_chunked_deframer.sv
verif/tb_http_chunked_deframer.sv
